// ----- rtl/frequency_ordered_list_macros.svh -----
// assertion macros for the frequency ordered list
`ifndef FREQUENCY_ORDERED_LIST_MACROS_SVH
`define FREQUENCY_ORDERED_LIST_MACROS_SVH
`ifndef ASSERT_OFF
`define FOL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define FOL_ASSERT_NEVER(lbl, cond, msg) `FOL_ASSERT(lbl, !(cond), msg)
`else
`define FOL_ASSERT(lbl, prop, msg)
`define FOL_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ----- rtl/fol_pkg.sv -----
package fol_pkg;

  localparam int DEPTH        = 16;
  localparam int COUNT_BITS   = 16;

  localparam int CMD_W        = 2;
  localparam int VALUE_W      = 32;
  localparam int ITEM_COUNT_W = 16;
  localparam int STATUS_W     = 3;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ACCESS = 2'd2;

  localparam logic [STATUS_W-1:0] ST_ENTRY    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_APPENDED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd4;

  // operation of the shared comparator
  typedef enum logic {
    CMP_EQ,
    CMP_GT
  } cmp_mode_e;

endpackage

// ----- rtl/fol_store.sv -----
module fol_store #(
  parameter int Depth     = fol_pkg::DEPTH,
  parameter int CountBits = fol_pkg::COUNT_BITS
) (
  input  logic                              clk_i,
  input  logic                              we_i,
  input  logic [$clog2(Depth)-1:0]          waddr_i,
  input  logic signed [fol_pkg::VALUE_W-1:0] wvalue_i,
  input  logic [CountBits-1:0]              wcount_i,
  input  logic [$clog2(Depth)-1:0]          raddr_i,
  output logic signed [fol_pkg::VALUE_W-1:0] rvalue_o,
  output logic [CountBits-1:0]              rcount_o
);

  logic signed [fol_pkg::VALUE_W-1:0] value_mem [Depth];
  logic [CountBits-1:0]               count_mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      value_mem[waddr_i] <= wvalue_i;
      count_mem[waddr_i] <= wcount_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rvalue_o <= value_mem[raddr_i];
    rcount_o <= count_mem[raddr_i];
  end

endmodule

// ----- rtl/fol_cmp.sv -----
module fol_cmp #(
  parameter int CountBits = fol_pkg::COUNT_BITS
) (
  input  fol_pkg::cmp_mode_e                 mode_i,
  input  logic signed [fol_pkg::VALUE_W-1:0] a_value_i,
  input  logic signed [fol_pkg::VALUE_W-1:0] b_value_i,
  input  logic [CountBits-1:0]               a_count_i,
  input  logic [CountBits-1:0]               b_count_i,
  output logic                               hit_o
);

  always_comb begin
    case (mode_i)
      fol_pkg::CMP_EQ: hit_o = (a_value_i == b_value_i);
      fol_pkg::CMP_GT: hit_o = (a_count_i > b_count_i);
      default:         hit_o = 1'b0;
    endcase
  end

endmodule

// ----- rtl/frequency_ordered_list.sv -----
// channel   signals                                          direction
// command   start_i busy_o command_i value_i                 in, taken on start_i && !busy_o
// result    strobe_o item_value_o item_count_o status_o last_o  out, single-cycle strobe_o
//
// clear, append and access of an empty list answer in the cycle after they are taken
// and raise no busy. any other access reads and compares one entry per probe; a miss
// ends there, a hit is sorted by selection and every entry listed: the list sits in one
// memory with a single registered read port, and one comparator serves search and sort.
// reset is asynchronous, active low, and empties the list; the receiver cannot stall.
`include "frequency_ordered_list_macros.svh"

module frequency_ordered_list #(
  parameter int Depth     = fol_pkg::DEPTH,
  parameter int CountBits = fol_pkg::COUNT_BITS
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    start_i,
  output logic                                    busy_o,
  input  logic [fol_pkg::CMD_W-1:0]               command_i,
  input  logic signed [fol_pkg::VALUE_W-1:0]      value_i,
  output logic                                    strobe_o,
  output logic signed [fol_pkg::VALUE_W-1:0]      item_value_o,
  output logic [fol_pkg::ITEM_COUNT_W-1:0]        item_count_o,
  output logic [fol_pkg::STATUS_W-1:0]            status_o,
  output logic                                    last_o
);

  localparam int IdxW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);
  localparam int OutCw = (CountBits < fol_pkg::ITEM_COUNT_W) ? CountBits
                                                               : fol_pkg::ITEM_COUNT_W;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SRCH_RD  = 4'd1;
  localparam logic [3:0] S_SRCH_CMP = 4'd2;
  localparam logic [3:0] S_SORT_RDI = 4'd3;
  localparam logic [3:0] S_SORT_LDI = 4'd4;
  localparam logic [3:0] S_SORT_RDJ = 4'd5;
  localparam logic [3:0] S_SORT_CMP = 4'd6;
  localparam logic [3:0] S_SWAP_A   = 4'd7;
  localparam logic [3:0] S_SWAP_B   = 4'd8;
  localparam logic [3:0] S_EMIT_RD  = 4'd9;
  localparam logic [3:0] S_EMIT_OUT = 4'd10;

  logic [3:0]      state_q, state_d;
  logic [CntW-1:0] total_q, total_d;
  logic [IdxW-1:0] i_q, i_d, j_q, j_d, best_q, best_d;

  logic signed [fol_pkg::VALUE_W-1:0] key_q, key_d;
  logic signed [fol_pkg::VALUE_W-1:0] a_val_q, a_val_d, b_val_q, b_val_d;
  logic [CountBits-1:0]               a_cnt_q, a_cnt_d, b_cnt_q, b_cnt_d;

  logic                                strobe_q, strobe_d;
  logic signed [fol_pkg::VALUE_W-1:0]  out_value_q, out_value_d;
  logic [fol_pkg::ITEM_COUNT_W-1:0]    out_count_q, out_count_d;
  logic [fol_pkg::STATUS_W-1:0]        out_status_q, out_status_d;
  logic                                out_last_q, out_last_d;

  logic                               mem_we;
  logic [IdxW-1:0]                    mem_waddr, mem_raddr;
  logic signed [fol_pkg::VALUE_W-1:0] mem_wvalue, rd_value;
  logic [CountBits-1:0]               mem_wcount, rd_count, inc_count;

  fol_pkg::cmp_mode_e cmp_mode;
  logic               cmp_hit;

  logic accept;
  logic i_at_end, j_at_end;
  logic [fol_pkg::ITEM_COUNT_W-1:0] rd_count_out;

  fol_store #(
    .Depth     (Depth),
    .CountBits (CountBits)
  ) u_store (
    .clk_i    (clk_i),
    .we_i     (mem_we),
    .waddr_i  (mem_waddr),
    .wvalue_i (mem_wvalue),
    .wcount_i (mem_wcount),
    .raddr_i  (mem_raddr),
    .rvalue_o (rd_value),
    .rcount_o (rd_count)
  );

  fol_cmp #(
    .CountBits (CountBits)
  ) u_cmp (
    .mode_i    (cmp_mode),
    .a_value_i (rd_value),
    .b_value_i (key_q),
    .a_count_i (rd_count),
    .b_count_i (b_cnt_q),
    .hit_o     (cmp_hit)
  );

  assign accept    = start_i && (state_q == S_IDLE);
  assign i_at_end  = ((CntW'(i_q) + 1'b1) >= total_q);
  assign j_at_end  = ((CntW'(j_q) + 1'b1) >= total_q);
  assign inc_count = (&rd_count) ? rd_count : rd_count + CountBits'(1);
  assign rd_count_out = fol_pkg::ITEM_COUNT_W'(rd_count[OutCw-1:0]);
  assign cmp_mode  = (state_q == S_SORT_CMP) ? fol_pkg::CMP_GT : fol_pkg::CMP_EQ;

  always_comb begin
    state_d      = state_q;
    total_d      = total_q;
    i_d          = i_q;
    j_d          = j_q;
    best_d       = best_q;
    key_d        = key_q;
    a_val_d      = a_val_q;
    a_cnt_d      = a_cnt_q;
    b_val_d      = b_val_q;
    b_cnt_d      = b_cnt_q;
    strobe_d     = 1'b0;
    out_value_d  = out_value_q;
    out_count_d  = out_count_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;
    mem_we       = 1'b0;
    mem_waddr    = i_q;
    mem_wvalue   = b_val_q;
    mem_wcount   = b_cnt_q;
    mem_raddr    = i_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          out_value_d = '0;
          out_count_d = '0;
          out_last_d  = 1'b1;
          case (command_i)
            fol_pkg::CMD_CLEAR: begin
              total_d      = '0;
              strobe_d     = 1'b1;
              out_status_d = fol_pkg::ST_CLEARED;
            end
            fol_pkg::CMD_APPEND: begin
              strobe_d = 1'b1;
              if (total_q == CntW'(Depth)) begin
                out_status_d = fol_pkg::ST_FULL;
              end else begin
                mem_we       = 1'b1;
                mem_waddr    = total_q[IdxW-1:0];
                mem_wvalue   = value_i;
                mem_wcount   = '0;
                total_d      = total_q + 1'b1;
                out_status_d = fol_pkg::ST_APPENDED;
              end
            end
            fol_pkg::CMD_ACCESS: begin
              if (total_q == '0) begin
                strobe_d     = 1'b1;
                out_status_d = fol_pkg::ST_NOTFOUND;
              end else begin
                key_d   = value_i;
                i_d     = '0;
                state_d = S_SRCH_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_SRCH_RD: begin
        mem_raddr = i_q;
        state_d   = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        if (cmp_hit) begin
          // count the first match, write it back, then sort from the head
          mem_we     = 1'b1;
          mem_waddr  = i_q;
          mem_wvalue = rd_value;
          mem_wcount = inc_count;
          i_d        = '0;
          state_d    = S_SORT_RDI;
        end else if (i_at_end) begin
          strobe_d     = 1'b1;
          out_value_d  = '0;
          out_count_d  = '0;
          out_status_d = fol_pkg::ST_NOTFOUND;
          out_last_d   = 1'b1;
          state_d      = S_IDLE;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = S_SRCH_RD;
        end
      end
      S_SORT_RDI: begin
        mem_raddr = i_q;
        if (i_at_end) begin
          j_d     = '0;
          state_d = S_EMIT_RD;
        end else begin
          state_d = S_SORT_LDI;
        end
      end
      S_SORT_LDI: begin
        a_val_d = rd_value;
        a_cnt_d = rd_count;
        b_val_d = rd_value;
        b_cnt_d = rd_count;
        best_d  = i_q;
        j_d     = i_q + 1'b1;
        state_d = S_SORT_RDJ;
      end
      S_SORT_RDJ: begin
        mem_raddr = j_q;
        state_d   = S_SORT_CMP;
      end
      S_SORT_CMP: begin
        // strictly larger only, so the first of equal maxima stays best
        if (cmp_hit) begin
          best_d  = j_q;
          b_val_d = rd_value;
          b_cnt_d = rd_count;
        end
        if (j_at_end) begin
          state_d = S_SWAP_A;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = S_SORT_RDJ;
        end
      end
      S_SWAP_A: begin
        if (best_q != i_q) begin
          mem_we     = 1'b1;
          mem_waddr  = i_q;
          mem_wvalue = b_val_q;
          mem_wcount = b_cnt_q;
          state_d    = S_SWAP_B;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = S_SORT_RDI;
        end
      end
      S_SWAP_B: begin
        mem_we     = 1'b1;
        mem_waddr  = best_q;
        mem_wvalue = a_val_q;
        mem_wcount = a_cnt_q;
        i_d        = i_q + 1'b1;
        state_d    = S_SORT_RDI;
      end
      S_EMIT_RD: begin
        mem_raddr = j_q;
        state_d   = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        strobe_d     = 1'b1;
        out_value_d  = rd_value;
        out_count_d  = rd_count_out;
        out_status_d = fol_pkg::ST_ENTRY;
        out_last_d   = j_at_end;
        if (j_at_end) begin
          state_d = S_IDLE;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = S_EMIT_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      total_q  <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      total_q  <= total_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q          <= i_d;
    j_q          <= j_d;
    best_q       <= best_d;
    key_q        <= key_d;
    a_val_q      <= a_val_d;
    a_cnt_q      <= a_cnt_d;
    b_val_q      <= b_val_d;
    b_cnt_q      <= b_cnt_d;
    out_value_q  <= out_value_d;
    out_count_q  <= out_count_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

  assign busy_o       = (state_q != S_IDLE);
  assign strobe_o     = strobe_q;
  assign item_value_o = out_value_q;
  assign item_count_o = out_count_q;
  assign status_o     = out_status_q;
  assign last_o       = out_last_q;

  `FOL_ASSERT(a_more_follow, (strobe_o && !last_o) |=> busy_o, "entry list cut short")
  `FOL_ASSERT(a_status_last, (strobe_o && status_o != fol_pkg::ST_ENTRY) |-> last_o,
              "status result not marked last")
  `FOL_ASSERT(a_empty_miss,
              (start_i && !busy_o && command_i == fol_pkg::CMD_ACCESS && total_q == '0)
              |=> (strobe_o && status_o == fol_pkg::ST_NOTFOUND),
              "access of empty list not reported")
  `FOL_ASSERT_NEVER(a_best_order, (state_q == S_SWAP_A) && (best_q < i_q),
                    "selected entry lies before sort position")
  `FOL_ASSERT_NEVER(a_total_range, total_q > CntW'(Depth), "entry total beyond depth")

endmodule
